@@ src/vtl_pkg.sv @@
// Package for the vertex transform and Lambert lighting block.
// Holds the register map, reset values and pipeline depths; it depends on nothing.
package vtl_pkg;

  // Register map, one entry per 64-bit slot of the configuration port.
  typedef enum logic [2:0] {
    REG_MODEL_X      = 3'd0,
    REG_MODEL_Y      = 3'd1,
    REG_MODEL_Z      = 3'd2,
    REG_NORMAL_X     = 3'd3,
    REG_NORMAL_Y     = 3'd4,
    REG_NORMAL_Z     = 3'd5,
    REG_LIGHT_DIR    = 3'd6,
    REG_LIGHT_LEVELS = 3'd7
  } reg_idx_e;

  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned ADDR_W     = 6;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned IN_W       = 120;
  localparam int unsigned OUT_W      = 72;

  // Root steps (one result bit each) and divide steps (one quotient bit each).
  localparam int unsigned SQ_STEPS   = 21;
  localparam int unsigned DV_STEPS   = 17;
  localparam int unsigned PIPE_DEPTH = 5 + SQ_STEPS + DV_STEPS + 2;

  localparam logic [12:0] ONE_Q12    = 13'd4096;

  // Reset value of each register: identity matrices, no light.
  function automatic logic [63:0] reg_reset(input reg_idx_e idx);
    logic [63:0] v;
    case (idx)
      REG_MODEL_X, REG_NORMAL_X: v = 64'd4096;
      REG_MODEL_Y, REG_NORMAL_Y: v = 64'd4096 << 16;
      REG_MODEL_Z, REG_NORMAL_Z: v = 64'd4096 << 32;
      default:                   v = '0;
    endcase
    return v;
  endfunction

  // Implemented bits of each register.
  function automatic logic [63:0] reg_mask(input reg_idx_e idx);
    logic [63:0] m;
    case (idx)
      REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z, REG_LIGHT_DIR: m = 64'h0000_FFFF_FFFF_FFFF;
      default:                                                 m = '1;
    endcase
    return m;
  endfunction

endpackage

@@ src/vertex_transform_lambert_light.sv @@
// Vertex transform and Lambert plus ambient lighting, top level.
// Depends on vtl_pkg for the register map, reset values and pipeline depths.

// One vertex enters per cycle while the output does not stall; most of the
// depth lies in the bit-serial square root (21 stages, one root bit each) and
// the restoring divider (17 stages, one quotient bit each) that normalise the
// lighting term. The whole pipeline moves as one: it advances whenever the
// output register is empty or its transfer completes, so a stall at the output
// holds every stage. Registers are written through the APB port at byte address
// 8*i and must only be changed while no vertex is in flight.
module vertex_transform_lambert_light (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z (16 b each), color_r, color_g, color_b (8 b)
  input  logic [vtl_pkg::IN_W-1:0]      s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // out_x, out_y, out_z (16 b each), lit_r, lit_g, lit_b (8 b each)
  output logic [vtl_pkg::OUT_W-1:0]     m_axis_tdata_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [vtl_pkg::ADDR_W-1:0]    paddr_i,
  input  logic [vtl_pkg::DATA_W-1:0]    pwdata_i,
  output logic [vtl_pkg::DATA_W-1:0]    prdata_o,
  output logic                          pready_o
);

  localparam int unsigned SQ = vtl_pkg::SQ_STEPS;
  localparam int unsigned DV = vtl_pkg::DV_STEPS;
  localparam int unsigned PD = vtl_pkg::PIPE_DEPTH;

  // Configuration registers.
  logic [63:0]        cfg_q [vtl_pkg::NUM_REGS];
  vtl_pkg::reg_idx_e  cfg_idx;
  logic               cfg_we;

  assign pready_o = 1'b1;
  assign cfg_idx  = vtl_pkg::reg_idx_e'(paddr_i[5:3]);
  assign cfg_we   = psel_i & penable_i & pwrite_i;
  assign prdata_o = cfg_q[paddr_i[5:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < vtl_pkg::NUM_REGS; r++) begin
        cfg_q[r] <= vtl_pkg::reg_reset(vtl_pkg::reg_idx_e'(r));
      end
    end else if (cfg_we) begin
      cfg_q[cfg_idx] <= pwdata_i & vtl_pkg::reg_mask(cfg_idx);
    end
  end

  // Pipeline advance and valid bits.
  logic          adv;
  logic [PD-1:0] vld_q;

  assign adv             = ~vld_q[PD-1] | m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[PD-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PD-2:0], s_axis_tvalid_i};
    end
  end

  // Stage 1: coefficient products.
  logic signed [31:0] pp_d [3][3], pp_q [3][3];
  logic signed [31:0] np_d [3][3], np_q [3][3];
  logic [23:0]        col1_q, col2_q, col3_q, col4_q;

  always_comb begin
    logic signed [15:0] c, v;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        c = cfg_q[i][16*j +: 16];
        v = s_axis_tdata_i[16*j +: 16];
        pp_d[i][j] = c * v;
        c = cfg_q[3+i][16*j +: 16];
        v = s_axis_tdata_i[48 + 16*j +: 16];
        np_d[i][j] = c * v;
      end
    end
  end

  // Stage 2: sums, rounding, saturation of the position.
  logic [15:0]        pos_d [3], pos2_q [3], pos3_q [3], pos4_q [3];
  logic signed [21:0] nq_d [3], nq_q [3];

  always_comb begin
    logic signed [15:0] tr;
    logic signed [33:0] acc, rnd, nacc, nrnd;
    for (int i = 0; i < 3; i++) begin
      tr   = cfg_q[i][63:48];
      acc  = (34'(tr) <<< 12) + 34'(pp_q[i][0]) + 34'(pp_q[i][1]) + 34'(pp_q[i][2])
             + 34'sd2048;
      rnd  = acc >>> 12;
      if (rnd > 34'sd32767) begin
        pos_d[i] = 16'h7FFF;
      end else if (rnd < -34'sd32768) begin
        pos_d[i] = 16'h8000;
      end else begin
        pos_d[i] = rnd[15:0];
      end
      nacc    = 34'(np_q[i][0]) + 34'(np_q[i][1]) + 34'(np_q[i][2]) + 34'sd2048;
      nrnd    = nacc >>> 12;
      nq_d[i] = nrnd[21:0];
    end
  end

  // Stage 3: squares of the rotated normal and products with the reversed light.
  logic signed [43:0] sqr_d [3], sqr_q [3];
  logic signed [38:0] dp_d [3], dp_q [3];

  always_comb begin
    logic signed [16:0] nl;
    for (int i = 0; i < 3; i++) begin
      nl       = -(17'(signed'(cfg_q[vtl_pkg::REG_LIGHT_DIR][16*i +: 16])));
      sqr_d[i] = nq_q[i] * nq_q[i];
      dp_d[i]  = nq_q[i] * nl;
    end
  end

  // Stage 4: squared length, dot product and intensity clamp.
  logic [41:0]        ss_d, ss_q;
  logic signed [40:0] dot_d, dot_q;
  logic [12:0]        inten_d, inten_q;

  always_comb begin
    logic signed [45:0] s;
    logic [15:0]        lv;
    s       = 46'(sqr_q[0]) + 46'(sqr_q[1]) + 46'(sqr_q[2]);
    ss_d    = s[41:0];
    dot_d   = 41'(dp_q[0]) + 41'(dp_q[1]) + 41'(dp_q[2]);
    lv      = cfg_q[vtl_pkg::REG_LIGHT_LEVELS][15:0];
    inten_d = (lv > 16'(vtl_pkg::ONE_Q12)) ? vtl_pkg::ONE_Q12 : lv[12:0];
  end

  // Stage 5 and the root steps: slot 0 holds the radicand and numerator.
  logic [41:0] rt_rad_q  [SQ+1];
  logic [23:0] rt_rem_q  [SQ+1], rt_rem_d [SQ+1];
  logic [20:0] rt_root_q [SQ+1], rt_root_d [SQ+1];
  logic [37:0] rt_num_q  [SQ+1];
  logic [15:0] rt_pos_q  [SQ+1][3];
  logic [23:0] rt_col_q  [SQ+1];
  logic        rt_dpos_q [SQ+1];
  logic [37:0] num_d;
  logic        dpos_d;

  always_comb begin
    logic [49:0] prod;
    dpos_d = ~dot_q[40] & (dot_q != '0);
    prod   = dot_q[36:0] * inten_q;
    num_d  = dpos_d ? prod[49:12] : '0;
  end

  // One root bit per step, two radicand bits brought down each time.
  always_comb begin
    logic [23:0] sh, trial;
    rt_rem_d[0]  = '0;
    rt_root_d[0] = '0;
    for (int k = 1; k <= SQ; k++) begin
      sh    = {rt_rem_q[k-1][21:0], rt_rad_q[k-1][43-2*k -: 2]};
      trial = {1'b0, rt_root_q[k-1], 2'b01};
      if (sh >= trial) begin
        rt_rem_d[k]  = sh - trial;
        rt_root_d[k] = {rt_root_q[k-1][19:0], 1'b1};
      end else begin
        rt_rem_d[k]  = sh;
        rt_root_d[k] = {rt_root_q[k-1][19:0], 1'b0};
      end
    end
  end

  // Divide steps: quotient of numerator over length, one bit per step.
  logic [37:0] dv_rem_q [DV], dv_rem_d [DV];
  logic [16:0] dv_quo_q [DV], dv_quo_d [DV];
  logic [20:0] dv_len_q [DV], dv_len_in [DV];
  logic        dv_use_q [DV], dv_use_in [DV];
  logic [15:0] dv_pos_q [DV][3], dv_pos_in [DV][3];
  logic [23:0] dv_col_q [DV], dv_col_in [DV];

  always_comb begin
    logic [37:0] rem, dsh;
    logic [16:0] quo;
    for (int d = 0; d < DV; d++) begin
      if (d == 0) begin
        rem          = rt_num_q[SQ];
        quo          = '0;
        dv_len_in[d] = rt_root_q[SQ];
        dv_use_in[d] = rt_dpos_q[SQ] & (rt_root_q[SQ] != '0);
        dv_pos_in[d] = rt_pos_q[SQ];
        dv_col_in[d] = rt_col_q[SQ];
      end else begin
        rem          = dv_rem_q[d-1];
        quo          = dv_quo_q[d-1];
        dv_len_in[d] = dv_len_q[d-1];
        dv_use_in[d] = dv_use_q[d-1];
        dv_pos_in[d] = dv_pos_q[d-1];
        dv_col_in[d] = dv_col_q[d-1];
      end
      dsh = 38'(dv_len_in[d]) << (DV - 1 - d);
      if (rem >= dsh) begin
        dv_rem_d[d] = rem - dsh;
        dv_quo_d[d] = {quo[15:0], 1'b1};
      end else begin
        dv_rem_d[d] = rem;
        dv_quo_d[d] = {quo[15:0], 1'b0};
      end
    end
  end

  // Channel factors: diffuse plus ambient, clamped to one.
  logic [12:0] fac_d [3], fac_q [3];
  logic [15:0] pos5_q [3];
  logic [23:0] col5_q;

  always_comb begin
    logic [16:0] dif;
    logic [17:0] sum;
    dif = dv_use_q[DV-1] ? dv_quo_q[DV-1] : '0;
    for (int c = 0; c < 3; c++) begin
      sum      = 18'(dif) + 18'(cfg_q[vtl_pkg::REG_LIGHT_LEVELS][16*(c+1) +: 16]);
      fac_d[c] = (sum > 18'(vtl_pkg::ONE_Q12)) ? vtl_pkg::ONE_Q12 : sum[12:0];
    end
  end

  // Output stage: colour scaling with rounding.
  logic [7:0]  lit_d [3], lit_q [3];
  logic [15:0] pos6_q [3];

  always_comb begin
    logic [20:0] p;
    for (int c = 0; c < 3; c++) begin
      p        = 21'(col5_q[8*c +: 8]) * 21'(fac_q[c]) + 21'd2048;
      lit_d[c] = p[19:12];
    end
  end

  assign m_axis_tdata_o = {lit_q[2], lit_q[1], lit_q[0], pos6_q[2], pos6_q[1], pos6_q[0]};

  // Payload registers, all moving with the pipeline advance.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pp_q   <= pp_d;
      np_q   <= np_d;
      col1_q <= s_axis_tdata_i[119:96];
      pos2_q <= pos_d;
      nq_q   <= nq_d;
      col2_q <= col1_q;
      sqr_q  <= sqr_d;
      dp_q   <= dp_d;
      pos3_q <= pos2_q;
      col3_q <= col2_q;
      ss_q    <= ss_d;
      dot_q   <= dot_d;
      inten_q <= inten_d;
      pos4_q  <= pos3_q;
      col4_q  <= col3_q;
      rt_rad_q[0]  <= ss_q;
      rt_rem_q[0]  <= rt_rem_d[0];
      rt_root_q[0] <= rt_root_d[0];
      rt_num_q[0]  <= num_d;
      rt_pos_q[0]  <= pos4_q;
      rt_col_q[0]  <= col4_q;
      rt_dpos_q[0] <= dpos_d;
      for (int k = 1; k <= SQ; k++) begin
        rt_rad_q[k]  <= rt_rad_q[k-1];
        rt_rem_q[k]  <= rt_rem_d[k];
        rt_root_q[k] <= rt_root_d[k];
        rt_num_q[k]  <= rt_num_q[k-1];
        rt_pos_q[k]  <= rt_pos_q[k-1];
        rt_col_q[k]  <= rt_col_q[k-1];
        rt_dpos_q[k] <= rt_dpos_q[k-1];
      end
      for (int d = 0; d < DV; d++) begin
        dv_rem_q[d] <= dv_rem_d[d];
        dv_quo_q[d] <= dv_quo_d[d];
        dv_len_q[d] <= dv_len_in[d];
        dv_use_q[d] <= dv_use_in[d];
        dv_pos_q[d] <= dv_pos_in[d];
        dv_col_q[d] <= dv_col_in[d];
      end
      fac_q  <= fac_d;
      pos5_q <= dv_pos_q[DV-1];
      col5_q <= dv_col_q[DV-1];
      lit_q  <= lit_d;
      pos6_q <= pos5_q;
    end
  end

endmodule
